@@ hdl/byte_ring_fifo_overwrite_defines.svh @@
// Shared assertion macros for the byte ring buffer.
`ifndef BYTE_RING_FIFO_OVERWRITE_DEFINES_SVH
`define BYTE_RING_FIFO_OVERWRITE_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define BRFO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define BRFO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/brfo_pkg.sv @@
package brfo_pkg;

    // Sizes
    localparam int STORE_DEPTH_DEF = 256;
    localparam int MAX_CHUNK       = 8;
    localparam int CAP_W           = 9;
    localparam int LEN_W           = 4;
    localparam int DATA_W          = 64;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // Operation codes
    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_PEEK = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_NO_DATA  = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

    // Register indexes
    localparam logic [0:0] REG_MODE = 1'b0;
    localparam logic [0:0] REG_CAP  = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] data_in;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] data_out;
        logic [CAP_W-1:0]  used_bytes;
        logic [CAP_W-1:0]  free_bytes;
        logic              is_empty;
        logic              is_full;
    } t_rsp;

    typedef struct packed {
        logic             overwrite_mode;
        logic [CAP_W-1:0] capacity;
        logic             clear;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_READ  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

@@ hdl/brfo_ram.sv @@
module brfo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, register the read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/brfo_regs.sv @@
module brfo_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [brfo_pkg::APB_AW-1:0]   paddr,
    input  logic [brfo_pkg::APB_DW-1:0]   pwdata,
    output logic [brfo_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output brfo_pkg::t_cfg                o_cfg
);
    import brfo_pkg::*;

    logic             r_mode;
    logic [CAP_W-1:0] r_cap;
    logic             w_wr;
    logic [0:0]       w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_AW-1:2];

    // Store register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_cap  <= CAP_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_MODE: r_mode <= pwdata[0];
                REG_CAP:  r_cap  <= pwdata[CAP_W-1:0];
                default:  ;
            endcase
        end
    end

    // Return register contents on read
    always_comb begin
        case (w_idx)
            REG_MODE: prdata = APB_DW'(r_mode);
            REG_CAP:  prdata = APB_DW'(r_cap);
            default:  prdata = '0;
        endcase
    end

    // Any register write raises clear, which empties the buffer if the engine is idle
    assign o_cfg.overwrite_mode = r_mode;
    assign o_cfg.capacity       = r_cap;
    assign o_cfg.clear          = w_wr;

endmodule

@@ hdl/brfo_engine.sv @@
module brfo_engine #(
    parameter int STORE_DEPTH = brfo_pkg::STORE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  brfo_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  brfo_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output brfo_pkg::t_rsp o_out_rsp
);
    import brfo_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = (AW < CAP_W) ? AW : CAP_W;

    t_state            r_state, n_state;
    logic [PW-1:0]     r_rd_ptr, r_wr_ptr, r_ptr;
    logic [CAP_W-1:0]  r_fill, r_new_fill;
    logic [LEN_W-1:0]  r_len, r_cnt, r_pos;
    logic              r_rvalid;
    logic [DATA_W-1:0] r_din, r_data;
    logic [1:0]        r_status;
    logic              r_commit_wr, r_commit_rd, r_ring_over;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [CAP_W-1:0]  w_cap;
    logic [CAP_W:0]    w_sum;
    logic [CAP_W-1:0]  w_room;
    logic              w_len_ok, w_accept, w_issue, w_we, w_load, w_last;
    logic [1:0]        w_status;
    logic [CAP_W-1:0]  w_new_fill;
    logic              w_commit_wr, w_commit_rd, w_ring_over;
    logic [PW:0]       w_ptr_inc;
    logic [PW-1:0]     w_ptr_next;
    logic [7:0]        w_rdata, w_wbyte;
    logic [AW-1:0]     w_addr;

    // Clamp the capacity to the storage; a capacity of zero counts as one
    always_comb begin
        if (i_cfg.capacity == '0) begin
            w_cap = CAP_W'(1);
        end else if (32'(i_cfg.capacity) > STORE_DEPTH) begin
            w_cap = CAP_W'(STORE_DEPTH);
        end else begin
            w_cap = i_cfg.capacity;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_len_ok   = (i_in_req.length != '0) && (i_in_req.length <= LEN_W'(MAX_CHUNK));
    assign w_sum      = {1'b0, r_fill} + (CAP_W+1)'(i_in_req.length);
    assign w_room     = w_cap - r_fill;

    // Decode the request against the current fill level
    always_comb begin
        w_status    = STATUS_OK;
        w_new_fill  = r_fill;
        w_commit_wr = 1'b0;
        w_commit_rd = 1'b0;
        w_ring_over = 1'b0;
        n_state     = S_DONE;
        if (i_in_req.kind == KIND_PUSH || i_in_req.kind == KIND_POP
                || i_in_req.kind == KIND_PEEK) begin
            if (!w_len_ok) begin
                w_status = STATUS_BAD_LEN;
            end else begin
                case (i_in_req.kind)
                    KIND_PUSH: begin
                        if (i_cfg.overwrite_mode
                                ? ((CAP_W+1)'(i_in_req.length) > {1'b0, w_cap})
                                : (CAP_W'(i_in_req.length) > w_room)) begin
                            w_status = STATUS_NO_SPACE;
                        end else begin
                            w_commit_wr = 1'b1;
                            n_state     = S_WRITE;
                            if (i_cfg.overwrite_mode && (w_sum > {1'b0, w_cap})) begin
                                w_ring_over = 1'b1;
                                w_new_fill  = w_cap;
                            end else begin
                                w_new_fill = w_sum[CAP_W-1:0];
                            end
                        end
                    end
                    KIND_POP, KIND_PEEK: begin
                        if (r_fill < CAP_W'(i_in_req.length)) begin
                            w_status = STATUS_NO_DATA;
                        end else begin
                            n_state = S_READ;
                            if (i_in_req.kind == KIND_POP) begin
                                w_commit_rd = 1'b1;
                                w_new_fill  = r_fill - CAP_W'(i_in_req.length);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // Step the byte pointer, wrapping at the capacity
    assign w_ptr_inc  = {1'b0, r_ptr} + (PW+1)'(1);
    assign w_ptr_next = ((CAP_W+1)'(w_ptr_inc) >= {1'b0, w_cap}) ? '0 : w_ptr_inc[PW-1:0];

    assign w_we    = (r_state == S_WRITE);
    assign w_issue = (r_state == S_READ) && (r_cnt != r_len);
    assign w_addr  = AW'(r_ptr);
    assign w_wbyte = r_din[8*r_cnt[2:0] +: 8];
    assign w_last  = (r_cnt == r_len - LEN_W'(1));
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    brfo_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wbyte),
        .o_rdata (w_rdata)
    );

    // Sequencer and buffer pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rvalid <= w_issue;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg.clear) begin
                        r_rd_ptr <= '0;
                        r_wr_ptr <= '0;
                        r_fill   <= '0;
                    end else if (w_accept) begin
                        r_state <= n_state;
                    end
                end
                S_WRITE: begin
                    if (w_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    if (r_rvalid && (r_pos == r_len - LEN_W'(1))) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                        r_fill  <= r_new_fill;
                        if (r_commit_wr) begin
                            r_wr_ptr <= r_ptr;
                        end
                        if (r_commit_rd || r_ring_over) begin
                            r_rd_ptr <= r_ptr;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Hold the result until the receiver takes it
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request working registers and byte gathering
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_len       <= i_in_req.length;
            r_din       <= i_in_req.data_in;
            r_status    <= w_status;
            r_new_fill  <= w_new_fill;
            r_commit_wr <= w_commit_wr;
            r_commit_rd <= w_commit_rd;
            r_ring_over <= w_ring_over;
            r_ptr       <= (i_in_req.kind == KIND_PUSH) ? r_wr_ptr : r_rd_ptr;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_data      <= '0;
        end else begin
            if (w_we || w_issue) begin
                r_ptr <= w_ptr_next;
                r_cnt <= r_cnt + LEN_W'(1);
            end
            if (r_rvalid) begin
                r_data[8*r_pos[2:0] +: 8] <= w_rdata;
                r_pos                     <= r_pos + LEN_W'(1);
            end
        end
    end

    // Build the result
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.status     <= r_status;
            r_out.data_out   <= r_data;
            r_out.used_bytes <= r_new_fill;
            r_out.free_bytes <= w_cap - r_new_fill;
            r_out.is_empty   <= (r_new_fill == '0);
            r_out.is_full    <= (r_new_fill == w_cap);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

@@ hdl/byte_ring_fifo_overwrite.sv @@
// Circular byte buffer with FIFO and overwrite (ring) modes.
// Request channel: i_in_valid / o_in_ready carry a push, pop or peek of
// 1 to 8 bytes packed in i_in_req. Result channel: o_out_valid /
// i_out_ready return one result per request with status, data and fill.
// Configuration: APB-style port, mode at 0x0, capacity at 0x4; any write
// empties the buffer. Write registers only while no request is in flight.
// Timing: the byte store is a single-port RAM that moves one byte per
// cycle, so once a request is taken a push writes its bytes in turn and
// a pop or peek reads them, gathering the registered RAM read data.
// A rejected request goes straight to the done state and does not touch
// the store. The result is loaded into the output register once that
// register is free, and the engine returns to idle with that load.
// A new request is taken as soon as the engine is idle, even while the
// last result waits in the output register for i_out_ready. A stalled
// receiver holds that result and stops the next one from loading.
// Reset: buffer empty, FIFO mode, capacity 256. Store contents are not
// cleared; only bytes written since the last emptying are ever read.
module byte_ring_fifo_overwrite #(
    parameter int STORE_DEPTH = brfo_pkg::STORE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  brfo_pkg::t_req              i_in_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output brfo_pkg::t_rsp              o_out_rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brfo_pkg::APB_AW-1:0] paddr,
    input  logic [brfo_pkg::APB_DW-1:0] pwdata,
    output logic [brfo_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import brfo_pkg::*;

    t_cfg w_cfg;

    brfo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    brfo_engine #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp)
    );

endmodule

@@ hdl/brfo_checker.sv @@
`include "byte_ring_fifo_overwrite_defines.svh"

module brfo_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input brfo_pkg::t_rsp o_out_rsp
);
    import brfo_pkg::*;

    // One request at a time: the engine is busy right after taking one
    `BRFO_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "request taken while engine busy")

    // A failed or rejected request returns no data
    `BRFO_ASSERT_SAME(a_fail_no_data, i_clk, i_rst_n, o_out_valid && (o_out_rsp.status != STATUS_OK), o_out_rsp.data_out == '0, "data returned with error status")

    // The full flag agrees with the counts and excludes empty
    `BRFO_ASSERT_SAME(a_full_no_free, i_clk, i_rst_n, o_out_valid && o_out_rsp.is_full, (o_out_rsp.free_bytes == '0) && !o_out_rsp.is_empty, "full flag with free space")

    // A stalled result holds
    `BRFO_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_rsp), "result changed while stalled")

endmodule

bind byte_ring_fifo_overwrite brfo_checker u_brfo_checker (.*);

@@ tb/sv/tb_top.sv @@
module tb_top;
    import brfo_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT = 16;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic o_in_ready;
    t_req in_req = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    t_rsp o_out_rsp;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // Shadow copy of the buffer
    logic [7:0] shadow_bytes [STORE_DEPTH_DEF];
    int shadow_rd = 0;
    int shadow_wr = 0;
    int shadow_fill = 0;
    logic ring_mode = 1'b0;
    logic [CAP_W-1:0] cap_setting = CAP_RESET;

    t_rsp awaited_rsps [$];

    int cycle_count = 0;
    int fail_count = 0;
    int results_seen = 0;
    int requests_sent = 0;
    int overwrite_pushes = 0;
    int rejected_ops = 0;
    int settings_used = 1;
    int hold_left = 0;
    bit steady = 1'b0;

    byte_ring_fifo_overwrite dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (o_out_rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the response to one request and advance the shadow buffer
    function automatic t_rsp predict_buffer_op(input t_req req);
        t_rsp rsp;
        int cap;
        int len;
        int idx;
        int i;
        rsp = '0;
        cap = (cap_setting == 0) ? 1 :
              (cap_setting > STORE_DEPTH_DEF) ? STORE_DEPTH_DEF : int'(cap_setting);
        len = req.length;
        if (shadow_fill > cap) shadow_fill = cap;
        if (req.kind == KIND_UNUSED) begin
            // ignored, state untouched
        end else if (len == 0 || len > MAX_CHUNK) begin
            rsp.status = STATUS_BAD_LEN;
        end else if (req.kind == KIND_PUSH) begin
            if (ring_mode ? (len > cap) : (len > cap - shadow_fill)) begin
                rsp.status = STATUS_NO_SPACE;
            end else begin
                idx = shadow_wr % cap;
                for (i = 0; i < len; i++) begin
                    shadow_bytes[idx] = req.data_in[8*i +: 8];
                    idx = (idx + 1 >= cap) ? 0 : idx + 1;
                end
                shadow_wr = idx;
                if (ring_mode && shadow_fill + len > cap) begin
                    shadow_rd = shadow_wr;
                    shadow_fill = cap;
                    overwrite_pushes++;
                end else begin
                    shadow_fill += len;
                end
            end
        end else if (shadow_fill < len) begin
            rsp.status = STATUS_NO_DATA;
        end else begin
            idx = shadow_rd % cap;
            for (i = 0; i < len; i++) begin
                rsp.data_out[8*i +: 8] = shadow_bytes[idx];
                idx = (idx + 1 >= cap) ? 0 : idx + 1;
            end
            if (req.kind == KIND_POP) begin
                shadow_rd = idx;
                shadow_fill -= len;
            end
        end
        if (rsp.status != STATUS_OK) rejected_ops++;
        rsp.used_bytes = CAP_W'(shadow_fill);
        rsp.free_bytes = CAP_W'(cap - shadow_fill);
        rsp.is_empty = (shadow_fill == 0);
        rsp.is_full = (shadow_fill == cap);
        return rsp;
    endfunction

    // Offer one request, hold it until accepted, then record its response
    task automatic send_request(input logic [1:0] kind, input logic [LEN_W-1:0] len,
                                input logic [DATA_W-1:0] data);
        t_req req;
        req.kind = kind;
        req.length = len;
        req.data_in = data;
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        awaited_rsps.push_back(predict_buffer_op(req));
        requests_sent++;
    endtask

    // Drop valid and wait until every response is back and the engine is quiet
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] which, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // any register write empties the buffer
        if (which == REG_MODE) ring_mode = value[0];
        else cap_setting = value[CAP_W-1:0];
        shadow_rd = 0;
        shadow_wr = 0;
        shadow_fill = 0;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic mode, input logic [CAP_W-1:0] cap);
        settle();
        write_reg(REG_MODE, {31'd0, mode});
        write_reg(REG_CAP, {23'd0, cap});
        settings_used++;
    endtask

    // Fresh out of reset: FIFO mode, capacity 256
    task automatic test_reset_state();
        send_request(KIND_POP, 4'd1, 64'd0);
        send_request(KIND_PEEK, 4'd8, 64'd0);
        send_request(KIND_PUSH, 4'd0, 64'hDEAD_BEEF_0000_0001);
        send_request(KIND_POP, 4'd15, 64'd0);
        send_request(KIND_UNUSED, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(KIND_PUSH, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(KIND_PUSH, 4'd1, 64'hFFFF_FFFF_FFFF_FF00);
        send_request(KIND_PEEK, 4'd8, 64'd0);
        send_request(KIND_POP, 4'd8, 64'd0);
        send_request(KIND_POP, 4'd1, 64'd0);
    endtask

    // FIFO rejects at the free-space edge and wraps at an odd capacity
    task automatic test_fifo_limits();
        configure(1'b0, 9'd13);
        send_request(KIND_PUSH, 4'd8, 64'h8877_6655_4433_2211);
        send_request(KIND_PUSH, 4'd8, 64'h1111_2222_3333_4444);
        send_request(KIND_PUSH, 4'd5, 64'h0000_00EE_DDCC_BBAA);
        send_request(KIND_POP, 4'd6, 64'd0);
        send_request(KIND_PUSH, 4'd6, 64'h0000_5A5A_A5A5_F00F);
        send_request(KIND_POP, 4'd8, 64'd0);
        send_request(KIND_PEEK, 4'd5, 64'd0);
        send_request(KIND_POP, 4'd5, 64'd0);
    endtask

    // Ring mode: too-long push rejected, overflow overwrites the oldest bytes
    task automatic test_ring_overwrite();
        configure(1'b1, 9'd5);
        send_request(KIND_PUSH, 4'd8, 64'h0102_0304_0506_0708);
        send_request(KIND_PUSH, 4'd3, 64'h0000_0000_0033_2211);
        send_request(KIND_PUSH, 4'd4, 64'h0000_0000_7766_5544);
        send_request(KIND_POP, 4'd5, 64'd0);
        send_request(KIND_PUSH, 4'd1, 64'h0000_0000_0000_0099);
        send_request(KIND_PUSH, 4'd5, 64'h0000_00C5_C4C3_C2C1);
    endtask

    // Capacity zero behaves as one byte
    task automatic test_capacity_clamp();
        configure(1'b0, 9'd0);
        send_request(KIND_PUSH, 4'd1, 64'h0000_0000_0000_0080);
        send_request(KIND_PUSH, 4'd1, 64'h0000_0000_0000_0001);
        send_request(KIND_POP, 4'd1, 64'd0);
    endtask

    // Hold off the response side so the block fills and stalls its input
    task automatic test_output_stall();
        int n;
        configure(1'b0, 9'd256);
        hold_left = 300;
        for (n = 0; n < 40; n++) begin
            send_request((n % 3 == 2) ? KIND_POP : KIND_PUSH,
                         LEN_W'($urandom_range(1, MAX_CHUNK)), {$urandom(), $urandom()});
        end
        // pause until every response is back, then resume
        settle();
        for (n = 0; n < 5; n++) begin
            send_request(KIND_POP, LEN_W'($urandom_range(1, MAX_CHUNK)), 64'd0);
        end
    endtask

    // Random mix under one setting; mostly legal requests with some noise
    task automatic run_phase(input logic mode, input logic [CAP_W-1:0] cap, input int count,
                             input int push_pct, input int max_len, input bit no_gaps);
        int n;
        int roll;
        logic [1:0] kind;
        logic [LEN_W-1:0] len;
        configure(mode, cap);
        steady = no_gaps;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 5) begin
                kind = 2'($urandom_range(3));
                len = LEN_W'($urandom_range(15));
            end else begin
                if ($urandom_range(99) < push_pct) kind = KIND_PUSH;
                else kind = ($urandom_range(3) == 0) ? KIND_PEEK : KIND_POP;
                len = LEN_W'($urandom_range(1, max_len));
            end
            send_request(kind, len, {$urandom(), $urandom()});
        end
        steady = 1'b0;
    endtask

    task automatic test_random();
        run_phase(1'b0, 9'd256, 300, 60, 8, 1'b0);
        run_phase(1'b0, 9'd1, 150, 50, 2, 1'b0);
        run_phase(1'b0, 9'd13, 250, 50, 8, 1'b0);
        run_phase(1'b1, 9'd7, 250, 55, 8, 1'b0);
        run_phase(1'b1, 9'd256, 300, 65, 8, 1'b0);
        run_phase(1'b1, 9'd0, 100, 50, 2, 1'b0);
        run_phase(1'b0, 9'd300, 200, 50, 8, 1'b1);
        run_phase(1'b1, 9'd511, 200, 60, 8, 1'b0);
        run_phase(1'b0, 9'd2, 100, 50, 3, 1'b0);
    endtask

    // Response side: random stalls, long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("response %0d: %s expected %0h, got %0h", results_seen, field, want, got);
        end
    endtask

    // Compare each accepted response with the oldest one awaited
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (awaited_rsps.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("response with no request outstanding: %0h", o_out_rsp);
            end else begin
                want = awaited_rsps.pop_front();
                check_field("status", want.status, o_out_rsp.status);
                check_field("data_out", want.data_out, o_out_rsp.data_out);
                check_field("used_bytes", want.used_bytes, o_out_rsp.used_bytes);
                check_field("free_bytes", want.free_bytes, o_out_rsp.free_bytes);
                check_field("is_empty", want.is_empty, o_out_rsp.is_empty);
                check_field("is_full", want.is_full, o_out_rsp.is_full);
            end
            results_seen++;
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk) cycle_count++;
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, awaited_rsps.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_fifo_limits();
        test_ring_overwrite();
        test_capacity_clamp();
        test_output_stall();
        test_random();

        settle();
        $display("Covered %0d requests over %0d buffer settings: %0d responses checked,",
                 requests_sent, settings_used, results_seen);
        $display("%0d rejected operations, %0d overwriting pushes, %0d cycles.",
                 rejected_ops, overwrite_pushes, cycle_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
